// File: rtl/core/tcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants
// Character codes, escape states, controller states and the command and
// status records that join the controller and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] ESC_CLEAR   = 8'd1;
  localparam logic [7:0] ESC_ATTR    = 8'd2;
  localparam logic [7:0] ESC_DEFAULT = 8'd3;
  localparam logic [7:0] ESC_COL     = 8'd4;
  localparam logic [7:0] ESC_ROW     = 8'd5;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [2:0] {
    ESC_NONE     = 3'd0,
    ESC_PENDING  = 3'd1,
    ESC_WANT_ATTR = 3'd2,
    ESC_WANT_COL = 3'd3,
    ESC_WANT_ROW = 3'd4
  } esc_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECIDE,
    ST_READ,
    ST_SCROLL,
    ST_FILL,
    ST_RESULT
  } state_t;

  // Fill modes for the sweep unit
  typedef enum logic [1:0] {
    FILL_ALL,
    FILL_ROW,
    FILL_LAST,
    FILL_ZERO
  } fill_t;

  // Controller to datapath
  typedef struct packed {
    logic  capture;     // latch the input item
    logic  decide;      // execute the byte, chooses any sweep
    logic  read_issue;  // read the addressed cell
    logic  scroll_step; // one step of the scroll copy
    logic  fill_step;   // one step of a blanking sweep
    logic  result_load; // load the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic  is_read;
    logic  need_scroll;
    logic  need_fill;
  } status_t;

endpackage
`default_nettype wire

// File: rtl/core/text_console_writer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer: character-cell text console
// Cell store with cursor, attributes and escape handling.
// ----------------------------------------------------------------------------
// After reset the block zeroes the cell store, one cell a cycle, and keeps
// in_ready low until that pass ends. An accepted item then passes a decide
// state, a read state (reads) or a scroll state (writes), and a result load
// state before its result is offered; the next item can be accepted in the
// same cycle as that result is taken. A newline blanks the new row, a clear
// blanks every cell, and a scroll copies each row up one, hands over and
// blanks the bottom row, all through the single write port of the cell
// store. Input is held off while a result waits.
module text_console_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        operation,
  input  wire logic [7:0]  char_code,
  input  wire logic [10:0] cell_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      cell_data,
  output logic [4:0]       cursor_row,
  output logic [6:0]       cursor_col,
  output logic             cursor_valid,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data
);
  import tcw_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    cursor_enable;

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) cursor_enable <= 1'b1;
    else if (cfg_valid) cursor_enable <= cfg_data;
  end

  tcw_control u_control (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .status, .cmd
  );

  tcw_datapath #(.COLS(COLS), .ROWS(ROWS)) u_datapath (
    .clk, .rst, .cmd, .status, .operation, .char_code, .cell_index,
    .cursor_enable, .cell_data, .cursor_row, .cursor_col, .cursor_valid
  );

  // Checks
  a_one_phase: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.decide, cmd.read_issue, cmd.scroll_step,
              cmd.fill_step, cmd.result_load})) else $error("overlapping commands");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |-> !in_ready) else $error("accept while busy");
  a_result_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |=> out_valid) else $error("result not shown");

endmodule
`default_nettype wire

// File: rtl/core/tcw_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_datapath: cell store, cursor and escape registers
// Executes one byte per decide command, and walks the cell store one cell a
// cycle for scroll, clear, row blanking and the zeroing pass after reset.
// ----------------------------------------------------------------------------
module tcw_datapath #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire tcw_pkg::cmd_t   cmd,
  output tcw_pkg::status_t     status,
  input  wire logic            operation,
  input  wire logic [7:0]      char_code,
  input  wire logic [10:0]     cell_index,
  input  wire logic            cursor_enable,
  output logic [15:0]          cell_data,
  output logic [4:0]           cursor_row,
  output logic [6:0]           cursor_col,
  output logic                 cursor_valid
);
  import tcw_pkg::*;

  localparam int NCELLS = COLS * ROWS;
  localparam int AW = $clog2(NCELLS + 1);
  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);
  localparam logic [AW-1:0] LAST_ROW_BASE = AW'((ROWS - 1) * COLS);
  localparam logic [AW-1:0] NCELLS_A = AW'(NCELLS);
  localparam logic [AW-1:0] COLS_A = AW'(COLS);

  logic [15:0] mem [NCELLS];

  // Captured item
  logic        op_q;
  logic [7:0]  ch_q;
  logic [10:0] idx_q;

  // Console state
  logic [RW-1:0] row_pos;
  logic [CW-1:0] col_pos;
  esc_t          esc;
  logic [7:0]    attribute;
  logic [7:0]    default_attribute;

  // Sweep state
  logic          scroll_req, fill_req;
  fill_t         fill_mode;
  logic [AW-1:0] sweep_addr, sweep_end;
  logic          copy_valid;
  logic [AW-1:0] copy_addr;
  logic [15:0]   rd_data;
  logic          rd_in_range;

  // Write port of the cell store, decided combinationally
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic [AW-1:0] raddr;

  logic [AW-1:0] cur_addr;
  assign cur_addr = AW'(row_pos) * COLS_A + AW'(col_pos);

  logic [15:0] blank;
  assign blank = {attribute, CH_SPACE};

  // Byte decode, used in the decide cycle
  logic is_plain, is_bs, is_nl;
  always_comb begin
    is_plain = 1'b0;
    is_bs    = 1'b0;
    unique case (esc)
      ESC_NONE: begin
        is_bs    = (ch_q == CH_BS);
        is_plain = (ch_q != CH_ESC) && (ch_q != CH_BS);
      end
      ESC_PENDING: begin
        is_plain = (ch_q != ESC_CLEAR) && (ch_q != ESC_ATTR) && (ch_q != ESC_DEFAULT)
                   && (ch_q != ESC_COL) && (ch_q != ESC_ROW);
      end
      default: ;
    endcase
    is_nl = is_plain && (ch_q == CH_NL);
  end

  logic last_row, last_col;
  assign last_row = (row_pos == RW'(ROWS - 1));
  assign last_col = (col_pos == CW'(COLS - 1));

  localparam logic [8:0] COLS9 = 9'(COLS);
  localparam logic [8:0] ROWS9 = 9'(ROWS);

  // Clamp of a set position byte
  logic [8:0] col_clamp, row_clamp;
  always_comb begin
    col_clamp = 9'd0;
    row_clamp = 9'd0;
    if (ch_q != 8'd0) begin
      col_clamp = ({1'b0, ch_q} > COLS9) ? COLS9 - 9'd1 : {1'b0, ch_q} - 9'd1;
      row_clamp = ({1'b0, ch_q} > ROWS9) ? ROWS9 - 9'd1 : {1'b0, ch_q} - 9'd1;
    end
  end

  // Write port select
  always_comb begin
    we    = 1'b0;
    waddr = cur_addr;
    wdata = blank;
    if (cmd.decide && !op_q) begin
      if (is_bs && col_pos != '0) begin
        we    = 1'b1;
        waddr = cur_addr - AW'(1);
      end else if (is_plain && !is_nl) begin
        we    = 1'b1;
        wdata = {attribute, ch_q};
      end
    end else if (cmd.scroll_step && copy_valid) begin
      we    = 1'b1;
      waddr = copy_addr;
      wdata = rd_data;
    end else if (cmd.fill_step) begin
      we    = 1'b1;
      waddr = sweep_addr;
      // The pass after reset leaves every cell at zero.
      if (fill_mode == FILL_ZERO) wdata = 16'd0;
    end
  end

  // Read address: the item's index or the scroll source
  always_comb begin
    raddr = sweep_addr + COLS_A;
    if (cmd.read_issue) raddr = idx_q[AW-1:0];
  end

  // Cell store
  always_ff @(posedge clk) begin
    if (we) mem[waddr[$clog2(NCELLS)-1:0]] <= wdata;
    rd_data <= mem[raddr[$clog2(NCELLS)-1:0]];
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= operation;
      ch_q  <= char_code;
      idx_q <= cell_index;
    end
  end

  // Console state and sweep control
  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos           <= '0;
      col_pos           <= '0;
      esc               <= ESC_NONE;
      attribute         <= '0;
      default_attribute <= '0;
      scroll_req        <= 1'b0;
      fill_req          <= 1'b1;
      fill_mode         <= FILL_ZERO;
      sweep_addr        <= '0;
      sweep_end         <= NCELLS_A - AW'(1);
      copy_valid        <= 1'b0;
      copy_addr         <= '0;
      rd_in_range       <= 1'b0;
    end else begin
      if (cmd.capture) begin
        scroll_req <= 1'b0;
        fill_req   <= 1'b0;
        copy_valid <= 1'b0;
      end
      if (cmd.read_issue) rd_in_range <= ({{(11-AW+1){1'b0}}, idx_q[AW-1:0]} == {1'b0, idx_q})
                                         && (idx_q[AW-1:0] < NCELLS_A);
      if (cmd.decide && !op_q) begin
        unique case (esc)
          ESC_NONE, ESC_PENDING: begin
            esc <= ESC_NONE;
            if (esc == ESC_NONE && ch_q == CH_ESC) begin
              esc <= ESC_PENDING;
            end else if (is_bs) begin
              if (col_pos != '0) col_pos <= col_pos - CW'(1);
            end else if (esc == ESC_PENDING && ch_q == ESC_CLEAR) begin
              row_pos    <= '0;
              col_pos    <= '0;
              fill_req   <= 1'b1;
              fill_mode  <= FILL_ALL;
              sweep_addr <= '0;
              sweep_end  <= NCELLS_A - AW'(1);
            end else if (esc == ESC_PENDING && ch_q == ESC_ATTR) begin
              esc <= ESC_WANT_ATTR;
            end else if (esc == ESC_PENDING && ch_q == ESC_DEFAULT) begin
              attribute <= default_attribute;
            end else if (esc == ESC_PENDING && ch_q == ESC_COL) begin
              esc <= ESC_WANT_COL;
            end else if (esc == ESC_PENDING && ch_q == ESC_ROW) begin
              esc <= ESC_WANT_ROW;
            end else if (is_nl || last_col) begin
              // Move to the next row: newline blanks it, wrap leaves it; on the last row both scroll
              col_pos <= '0;
              if (last_row) begin
                scroll_req <= 1'b1;
                sweep_addr <= '0;
                sweep_end  <= LAST_ROW_BASE - AW'(1);
              end else begin
                row_pos <= row_pos + RW'(1);
                if (is_nl) begin
                  fill_req   <= 1'b1;
                  fill_mode  <= FILL_ROW;
                  sweep_addr <= cur_addr - AW'(col_pos) + COLS_A;
                  sweep_end  <= cur_addr - AW'(col_pos) + COLS_A + COLS_A - AW'(1);
                end
              end
            end else begin
              col_pos <= col_pos + CW'(1);
            end
          end
          ESC_WANT_ATTR: begin
            esc       <= ESC_NONE;
            attribute <= ch_q;
            if (default_attribute == 8'd0) default_attribute <= ch_q;
          end
          ESC_WANT_COL: begin
            esc     <= ESC_NONE;
            col_pos <= col_clamp[CW-1:0];
          end
          ESC_WANT_ROW: begin
            esc     <= ESC_NONE;
            row_pos <= row_clamp[RW-1:0];
          end
          default: esc <= ESC_NONE;
        endcase
      end
      // Scroll copy: read one cell a row below into a register, then write it a row up
      if (cmd.scroll_step) begin
        copy_valid <= (sweep_addr <= sweep_end);
        copy_addr  <= sweep_addr;
        if (sweep_addr <= sweep_end) sweep_addr <= sweep_addr + AW'(1);
        if (copy_valid && copy_addr == sweep_end) begin
          scroll_req <= 1'b0;
          copy_valid <= 1'b0;
          fill_req   <= 1'b1;
          fill_mode  <= FILL_LAST;
          sweep_addr <= LAST_ROW_BASE;
          sweep_end  <= NCELLS_A - AW'(1);
          row_pos    <= RW'(ROWS - 1);
          col_pos    <= '0;
        end
      end
      if (cmd.fill_step) begin
        sweep_addr <= sweep_addr + AW'(1);
        if (sweep_addr == sweep_end) fill_req <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      cell_data    <= (op_q == OP_READ && rd_in_range) ? rd_data : 16'd0;
      cursor_row   <= 5'(row_pos);
      cursor_col   <= 7'(col_pos);
      cursor_valid <= cursor_enable;
    end
  end

  assign status.is_read     = op_q;
  assign status.need_scroll = scroll_req;
  assign status.need_fill   = fill_req;

endmodule
`default_nettype wire

// File: rtl/core/tcw_control.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_control: sequencer of the text console
// Zeroes the cell store after reset, accepts an item, issues the decide and
// any read command, runs any sweep, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module tcw_control (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire tcw_pkg::status_t  status,
  output tcw_pkg::cmd_t          cmd
);
  import tcw_pkg::*;

  state_t state, state_next;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT:   if (!status.need_fill) state_next = ST_IDLE;
      ST_IDLE:   if (in_valid) state_next = ST_DECIDE;
      ST_DECIDE: state_next = status.is_read ? ST_READ : ST_SCROLL;
      ST_READ:   state_next = ST_RESULT;
      ST_SCROLL: begin
        priority if (status.need_scroll) state_next = ST_SCROLL;
        else if (status.need_fill) state_next = ST_FILL;
        else state_next = ST_RESULT;
      end
      ST_FILL:   if (!status.need_fill) state_next = ST_RESULT;
      ST_RESULT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
    if (state == ST_IDLE && out_valid && !out_ready && in_valid) state_next = ST_IDLE;
  end

  // Outputs
  always_comb begin
    cmd = '0;
    in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
    unique case (state)
      ST_INIT:   cmd.fill_step = status.need_fill;
      ST_IDLE:   cmd.capture = in_valid && in_ready;
      ST_DECIDE: cmd.decide = 1'b1;
      ST_READ:   cmd.read_issue = 1'b1;
      ST_SCROLL: cmd.scroll_step = status.need_scroll;
      ST_FILL:   cmd.fill_step = status.need_fill;
      ST_RESULT: cmd.result_load = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= (state == ST_IDLE && !(in_valid && in_ready)) ? ST_IDLE : state_next;
      if (state == ST_RESULT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: text_console_writer testbench
// Sends written bytes, escape sequences and cell reads with random gaps on
// both channels. A predictor of the console state works out the expected
// cell value and cursor for every item. Results are checked in order.
// ----------------------------------------------------------------------------
module tb_top;
  import tcw_pkg::*;

  localparam int NCOLS = 80;
  localparam int NROWS = 25;
  localparam int NCELLS = NCOLS * NROWS;
  localparam int IDLE_LIMIT = 20000;
  localparam int TAIL_CYCLES = 40;

  // Expected-result record for one item
  typedef struct {
    logic [15:0] data;
    logic [4:0]  row;
    logic [6:0]  col;
    logic        shown;
  } console_result_t;

  // Console predictor and store of pending results
  class console_board;
    logic [15:0] screen [NCELLS];
    int          row;
    int          col;
    esc_t        esc;
    logic [7:0]  attr;
    logic [7:0]  dflt_attr;
    logic        cursor_on;
    console_result_t awaited [$];
    int          errors;
    int          checked;

    function new();
      foreach (screen[i]) screen[i] = '0;
      row = 0;
      col = 0;
      esc = ESC_NONE;
      attr = '0;
      dflt_attr = '0;
      cursor_on = 1'b1;
      errors = 0;
      checked = 0;
    endfunction

    function logic [15:0] blank();
      return {attr, CH_SPACE};
    endfunction

    function void blank_line(int r);
      for (int x = 0; x < NCOLS; x++) screen[r * NCOLS + x] = blank();
    endfunction

    function void scroll();
      for (int i = 0; i + NCOLS < NCELLS; i++) screen[i] = screen[i + NCOLS];
      blank_line(NROWS - 1);
      row = NROWS - 1;
      col = 0;
    endfunction

    function int clamp(int c, int lim);
      if (c == 0) return 0;
      if (c - 1 > lim - 1) return lim - 1;
      return c - 1;
    endfunction

    // Print a byte or take a newline, with wrap and scroll
    function void put_plain(logic [7:0] c);
      if (c == CH_NL) begin
        col = 0;
        if (row + 1 >= NROWS) scroll();
        else begin
          row++;
          blank_line(row);
        end
        return;
      end
      screen[row * NCOLS + col] = {attr, c};
      col++;
      if (col >= NCOLS) begin
        col = 0;
        if (row + 1 >= NROWS) scroll();
        else row++;
      end
    endfunction

    function void put_byte(logic [7:0] c);
      case (esc)
        ESC_NONE: begin
          if (c == CH_ESC) esc = ESC_PENDING;
          else if (c == CH_BS) begin
            if (col > 0) begin
              col--;
              screen[row * NCOLS + col] = blank();
            end
          end else put_plain(c);
        end
        ESC_PENDING: begin
          esc = ESC_NONE;
          if (c == ESC_CLEAR) begin
            foreach (screen[i]) screen[i] = blank();
            row = 0;
            col = 0;
          end else if (c == ESC_ATTR) esc = ESC_WANT_ATTR;
          else if (c == ESC_DEFAULT) attr = dflt_attr;
          else if (c == ESC_COL) esc = ESC_WANT_COL;
          else if (c == ESC_ROW) esc = ESC_WANT_ROW;
          else put_plain(c);
        end
        ESC_WANT_ATTR: begin
          esc = ESC_NONE;
          attr = c;
          if (dflt_attr == 0) dflt_attr = c;
        end
        ESC_WANT_COL: begin
          esc = ESC_NONE;
          col = clamp(int'(c), NCOLS);
        end
        ESC_WANT_ROW: begin
          esc = ESC_NONE;
          row = clamp(int'(c), NROWS);
        end
        default: esc = ESC_NONE;
      endcase
    endfunction

    // Note an accepted item and queue the result it should give
    function void note_input(logic op, logic [7:0] c, logic [10:0] idx);
      console_result_t r;
      r.data = '0;
      if (op == OP_WRITE) put_byte(c);
      else if (idx < NCELLS) r.data = screen[idx];
      r.row = row[4:0];
      r.col = col[6:0];
      r.shown = cursor_on;
      awaited.push_back(r);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(logic [15:0] d, logic [4:0] r, logic [6:0] c, logic v);
      console_result_t e;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result data=%h row=%0d col=%0d", d, r, c));
        return;
      end
      e = awaited.pop_front();
      checked++;
      if (d !== e.data)
        report($sformatf("result %0d cell_data %h, want %h", checked, d, e.data));
      if (r !== e.row)
        report($sformatf("result %0d cursor_row %0d, want %0d", checked, r, e.row));
      if (c !== e.col)
        report($sformatf("result %0d cursor_col %0d, want %0d", checked, c, e.col));
      if (v !== e.shown)
        report($sformatf("result %0d cursor_valid %b, want %b", checked, v, e.shown));
    endtask

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        operation = OP_WRITE;
  logic [7:0]  char_code = '0;
  logic [10:0] cell_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] cell_data;
  logic [4:0]  cursor_row;
  logic [6:0]  cursor_col;
  logic        cursor_valid;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  console_board board = new();
  int  items_sent = 0;
  int  reads_sent = 0;
  int  escapes_sent = 0;
  int  idle_count = 0;
  int  hold_request = 0;
  bit  send_fast = 1'b0;
  bit  take_fast = 1'b0;

  text_console_writer #(.COLS(NCOLS), .ROWS(NROWS)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .char_code(char_code), .cell_index(cell_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .cell_data(cell_data), .cursor_row(cursor_row), .cursor_col(cursor_col),
    .cursor_valid(cursor_valid),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Offer one item after a random gap and wait for it to be taken
  task send_item(logic op, logic [7:0] c, logic [10:0] idx);
    int gap;
    gap = send_fast ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    char_code <= c;
    cell_index <= idx;
    do @(posedge clk); while (!in_ready);
    board.note_input(op, c, idx);
    items_sent++;
    if (op == OP_READ) reads_sent++;
  endtask

  task send_char(logic [7:0] c);
    send_item(OP_WRITE, c, 11'($urandom_range(0, 2047)));
  endtask

  task send_read(logic [10:0] idx);
    send_item(OP_READ, 8'($urandom_range(0, 255)), idx);
  endtask

  task send_escape(logic [7:0] code, logic [7:0] arg);
    escapes_sent++;
    send_char(CH_ESC);
    send_char(code);
    if (code == ESC_ATTR || code == ESC_COL || code == ESC_ROW) send_char(arg);
  endtask

  // Wait until every expected result has come
  task drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Let the block drain, then write the cursor enable register
  task write_cursor_enable(logic v);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.cursor_on = v;
  endtask

  // One random item, or a whole escape sequence
  task send_random();
    int pick;
    int code;
    pick = $urandom_range(0, 99);
    if (pick < 40) send_char(8'($urandom_range(0, 255)));
    else if (pick < 48) send_char(CH_NL);
    else if (pick < 54) send_char(CH_BS);
    else if (pick < 72) begin
      code = $urandom_range(0, 20);
      if (code == 0) send_escape(ESC_CLEAR, 8'd0);
      else if (code < 6) send_escape(ESC_ATTR, 8'($urandom_range(0, 255)));
      else if (code < 8) send_escape(ESC_DEFAULT, 8'd0);
      else if (code < 12) send_escape(ESC_COL, 8'($urandom_range(0, 255)));
      else if (code < 17) send_escape(ESC_ROW, 8'($urandom_range(0, 1) ?
                                      $urandom_range(0, 30) : $urandom_range(0, 255)));
      else send_escape(8'($urandom_range(0, 255)), 8'd0);
    end else if (pick < 95) send_read(11'($urandom_range(0, NCELLS - 1)));
    else send_read(11'($urandom_range(NCELLS, 2047)));
  endtask

  task random_phase(int count);
    int start;
    start = items_sent;
    while (items_sent - start < count) begin
      if ($urandom_range(0, 49) == 0) send_fast = ~send_fast;
      send_random();
    end
  endtask

  // Receiver: random stalls, with a long hold-off when one is requested
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 49) == 0) take_fast = ~take_fast;
      gap = take_fast ? 0 : $urandom_range(0, 18);
      if (hold_request > 0) begin
        gap = hold_request;
        hold_request = 0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_result(cell_data, cursor_row, cursor_col, cursor_valid);
  end

  // Watchdog on cycles with no item moving on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_count <= 0;
    else if (idle_count >= IDLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else idle_count <= idle_count + 1;
  end

  // Main sequence
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_cursor_enable(1'b1);

    // Directed part; cells read before any write must come back as zero
    send_read(11'd0);
    send_read(11'd1234);
    send_escape(ESC_CLEAR, 8'd0);
    send_char(8'h41);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CH_NL);
    send_char(CH_BS);
    send_char(8'h42);
    send_char(CH_BS);
    send_escape(ESC_ATTR, 8'h1E);
    send_escape(ESC_ATTR, 8'h70);
    send_escape(ESC_DEFAULT, 8'd0);
    send_escape(ESC_COL, 8'd0);
    send_escape(ESC_COL, 8'd200);
    send_char(8'h43);
    send_escape(ESC_ROW, 8'd255);
    send_escape(ESC_COL, 8'd80);
    send_char(8'h44);
    send_escape(8'h09, 8'd0);
    send_escape(CH_ESC, 8'd0);
    send_escape(CH_NL, 8'd0);
    send_read(11'd0);
    send_read(11'd1999);
    send_read(11'd2047);
    send_read(11'd1920);

    write_cursor_enable(1'b0);
    random_phase(150);
    // Long receiver hold-off while items keep coming
    hold_request = 400;
    send_fast = 1'b1;
    random_phase(200);

    write_cursor_enable(1'b1);
    random_phase(170);
    // Sender waits for every result before going on
    drain();
    random_phase(180);

    write_cursor_enable(1'b0);
    random_phase(300);
    write_cursor_enable(1'b1);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d items: %0d cell reads, %0d escape sequences.",
             items_sent, reads_sent, escapes_sent);
    $display("Checked %0d results; cursor enable toggled between both values.",
             board.checked);
    if (board.errors == 0 && board.pending() == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_datapath.sv
rtl/core/tcw_control.sv
rtl/core/text_console_writer.sv
verif/tb_top.sv
